// ===== src/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register map, sequencer states and the configuration bundle
// shared by the PID controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

  // Fixed point format: Q16.16 in 32 bits
  localparam int DataWidth   = 32;
  localparam int FracBits    = 16;
  localparam int TargetWidth = 16;
  localparam int DriveWidth  = 16;
  localparam int PeriodWidth = 31;

  // APB register file
  localparam int ApbAddrWidth = 5;
  localparam int ApbDataWidth = 32;
  localparam int RegIdxWidth  = 3;

  // Divider: numerator is the difference scaled by 2^FracBits
  localparam int DivNumWidth = DataWidth + FracBits;
  localparam int DivCntWidth = $clog2(DivNumWidth + 1);

  // Register indexes
  typedef enum logic [RegIdxWidth-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_OUT_MIN,
    REG_OUT_MAX,
    REG_SAMPLE_PERIOD,
    REG_WINDUP_HIGH,
    REG_WINDUP_LOW
  } pca_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL_P,
    S_MUL_I1,
    S_MUL_I2,
    S_INT_ADD,
    S_WAIT_DIV,
    S_D_ADD,
    S_SUM,
    S_DONE
  } pca_state_e;

  // Configuration bundle from the register file to the datapath
  typedef struct packed {
    logic signed [DataWidth-1:0] gain_p;
    logic signed [DataWidth-1:0] gain_i;
    logic signed [DataWidth-1:0] gain_d;
    logic signed [DataWidth-1:0] out_min;
    logic signed [DataWidth-1:0] out_max;
    logic [PeriodWidth-1:0]      sample_period;
    logic signed [DataWidth-1:0] windup_high;
    logic signed [DataWidth-1:0] windup_low;
  } pca_cfg_t;

endpackage

`default_nettype wire

// ===== src/pca_if.sv =====
// ----------------------------------------------------------------------------
// PID controller channel interfaces
// Valid/ready channels for the sample input and the drive output.
// ----------------------------------------------------------------------------
`default_nettype none

interface pca_in_if;
  import pca_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [TargetWidth-1:0] target;
  logic signed [DataWidth-1:0]   measured;
  logic                          clear_state;

  modport source (output valid, output target, output measured, output clear_state,
                  input ready);
  modport sink   (input valid, input target, input measured, input clear_state,
                  output ready);
endinterface

interface pca_out_if;
  import pca_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DriveWidth-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ===== src/pca_cfg.sv =====
// ----------------------------------------------------------------------------
// PID controller register file
// APB-style configuration registers: gains, clamps, sample period, window.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pca_pkg::ApbAddrWidth-1:0] paddr,
  input  wire logic [pca_pkg::ApbDataWidth-1:0] pwdata,
  output logic      [pca_pkg::ApbDataWidth-1:0] prdata,
  output logic                                  pready,
  output pca_pkg::pca_cfg_t                     cfg_o
);
  import pca_pkg::*;

  pca_cfg_t cfg_q;
  pca_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = pca_reg_e'(paddr[2 +: RegIdxWidth]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Write the addressed register at the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= '0;
      cfg_q.gain_i        <= '0;
      cfg_q.gain_d        <= '0;
      cfg_q.out_min       <= {1'b1, {(DataWidth-1){1'b0}}};
      cfg_q.out_max       <= {1'b0, {(DataWidth-1){1'b1}}};
      cfg_q.sample_period <= PeriodWidth'(1) << FracBits;
      cfg_q.windup_high   <= {1'b0, {(DataWidth-1){1'b1}}};
      cfg_q.windup_low    <= {1'b1, {(DataWidth-1){1'b0}}};
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_P:        cfg_q.gain_p        <= pwdata;
        REG_GAIN_I:        cfg_q.gain_i        <= pwdata;
        REG_GAIN_D:        cfg_q.gain_d        <= pwdata;
        REG_OUT_MIN:       cfg_q.out_min       <= pwdata;
        REG_OUT_MAX:       cfg_q.out_max       <= pwdata;
        REG_SAMPLE_PERIOD: cfg_q.sample_period <= pwdata[PeriodWidth-1:0];
        REG_WINDUP_HIGH:   cfg_q.windup_high   <= pwdata;
        REG_WINDUP_LOW:    cfg_q.windup_low    <= pwdata;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P:        prdata = cfg_q.gain_p;
      REG_GAIN_I:        prdata = cfg_q.gain_i;
      REG_GAIN_D:        prdata = cfg_q.gain_d;
      REG_OUT_MIN:       prdata = cfg_q.out_min;
      REG_OUT_MAX:       prdata = cfg_q.out_max;
      REG_SAMPLE_PERIOD: prdata = {1'b0, cfg_q.sample_period};
      REG_WINDUP_HIGH:   prdata = cfg_q.windup_high;
      REG_WINDUP_LOW:    prdata = cfg_q.windup_low;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pca_mul.sv =====
// ----------------------------------------------------------------------------
// PID controller shared multiplier
// Signed fixed point multiply with registered product; the result is the
// product shifted right by the fraction bits (floor) and wrapped.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [pca_pkg::DataWidth-1:0] a_i,
  input  wire logic signed [pca_pkg::DataWidth-1:0] b_i,
  output logic signed      [pca_pkg::DataWidth-1:0] res_o
);
  import pca_pkg::*;

  logic signed [2*DataWidth-1:0] prod_q;

  // Register the full product
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Arithmetic shift then wrap is a plain slice of the product
  assign res_o = prod_q[FracBits +: DataWidth];

endmodule

`default_nettype wire

// ===== src/pca_div.sv =====
// ----------------------------------------------------------------------------
// PID controller divider
// Restoring divider, one quotient bit a cycle: (num * 2^FracBits) / den,
// truncated toward zero, wrapped; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [pca_pkg::DataWidth-1:0] num_i,
  input  wire logic        [pca_pkg::PeriodWidth-1:0] den_i,
  output logic                                      busy_o,
  output logic signed      [pca_pkg::DataWidth-1:0] quot_o
);
  import pca_pkg::*;

  logic                   busy_q;
  logic [DivCntWidth-1:0] cnt_q;
  logic [PeriodWidth-1:0] den_q;
  logic [PeriodWidth-1:0] rem_q;
  logic [DivNumWidth-1:0] quo_q;
  logic                   neg_q;
  logic                   zero_q;

  logic [DataWidth-1:0]   num_mag;
  logic [PeriodWidth:0]   rem_sh;
  logic [PeriodWidth:0]   rem_sub;
  logic                   bit_ge;
  logic [DataWidth-1:0]   quo_lo;

  assign num_mag = num_i[DataWidth-1] ? DataWidth'(-num_i) : DataWidth'(num_i);

  // One restoring step
  assign rem_sh  = {rem_q, quo_q[DivNumWidth-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign bit_ge  = rem_sh >= {1'b0, den_q};

  // Control: iteration count and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntWidth'(DivNumWidth);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != DivCntWidth'(1));
    end
  end

  // Datapath: load operands, then shift in a quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= '0;
      quo_q  <= {num_mag, {FracBits{1'b0}}};
      neg_q  <= num_i[DataWidth-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= bit_ge ? rem_sub[PeriodWidth-1:0] : rem_sh[PeriodWidth-1:0];
      quo_q <= {quo_q[DivNumWidth-2:0], bit_ge};
    end
  end

  // Apply sign and zero divisor rule
  assign quo_lo = quo_q[DataWidth-1:0];
  assign busy_o = busy_q;
  assign quot_o = zero_q ? '0 : (neg_q ? DataWidth'(-quo_lo) : quo_lo);

endmodule

`default_nettype wire

// ===== src/pid_controller_anti_windup_top.sv =====
// ----------------------------------------------------------------------------
// PID controller with integrator reset anti-windup
// Q16.16 PID loop run by a small sequencer around one shared multiplier and
// a bit-serial divider.
//
//   Channel    Dir  Handshake        Payload
//   sample_i   in   valid/ready      target, measured, clear_state
//   result_o   out  valid/ready      drive
//   APB        in   psel/penable     8 registers at byte address 4*i
//
// Transaction length, acceptance to drive result, is set mainly by the
// 48-step divider for the derivative term; the proportional and integral
// multiplies share one registered multiplier and overlap the division, the
// derivative multiply follows it. sample_i is ready only while the sequencer
// idles, so a sample is taken only after the last one is through. A finished
// drive waits in the output register, so the next sample is taken while it
// is pending. Reset clears integrator and previous error, restores config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_anti_windup_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pca_pkg::ApbAddrWidth-1:0] paddr,
  input  wire logic [pca_pkg::ApbDataWidth-1:0] pwdata,
  output logic      [pca_pkg::ApbDataWidth-1:0] prdata,
  output logic                                  pready,
  pca_in_if.sink                                sample_i,
  pca_out_if.source                             result_o
);
  import pca_pkg::*;

  pca_cfg_t   cfg;
  pca_state_e state_q, state_d;

  logic signed [TargetWidth-1:0] tgt_q;
  logic signed [DataWidth-1:0]   meas_q;
  logic signed [DataWidth-1:0]   err_q;
  logic signed [DataWidth-1:0]   p_q;
  logic signed [DataWidth-1:0]   i_q;
  logic signed [DataWidth-1:0]   pd_q;
  logic signed [DataWidth-1:0]   sum_q;
  logic signed [DataWidth-1:0]   acc_q;
  logic signed [DataWidth-1:0]   prev_q;
  logic signed [DriveWidth-1:0]  drive_q;
  logic                          out_valid_q;

  logic signed [DataWidth-1:0]   mul_a, mul_b, mul_res;
  logic                          div_start, div_busy;
  logic signed [DataWidth-1:0]   div_quot;
  logic signed [DataWidth-1:0]   clamped;
  logic                          in_accept, out_free, in_window;

  // Register file
  pca_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Shared multiplier
  pca_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  // Derivative divider
  pca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (err_q - prev_q),
    .den_i   (cfg.sample_period),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign in_accept = sample_i.valid && sample_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;
  assign in_window = !((i_q > cfg.windup_high) || (i_q < cfg.windup_low));

  // Clamp the sum, upper limit first
  always_comb begin
    if (sum_q > cfg.out_max) begin
      clamped = cfg.out_max;
    end else if (sum_q < cfg.out_min) begin
      clamped = cfg.out_min;
    end else begin
      clamped = sum_q;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, multiplier operands and divider start
  always_comb begin
    state_d        = state_q;
    mul_a          = cfg.gain_p;
    mul_b          = err_q;
    div_start      = 1'b0;
    sample_i.ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        sample_i.ready = 1'b1;
        if (sample_i.valid) state_d = S_ERR;
      end
      S_ERR:     state_d = S_MUL_P;
      S_MUL_P: begin
        div_start = 1'b1;
        state_d   = S_MUL_I1;
      end
      S_MUL_I1: begin
        mul_a   = cfg.gain_i;
        state_d = S_MUL_I2;
      end
      S_MUL_I2: begin
        mul_a   = mul_res;
        mul_b   = {1'b0, cfg.sample_period};
        state_d = S_INT_ADD;
      end
      S_INT_ADD: state_d = S_WAIT_DIV;
      S_WAIT_DIV: begin
        mul_a = cfg.gain_d;
        mul_b = div_quot;
        if (!div_busy) state_d = S_D_ADD;
      end
      S_D_ADD:   state_d = S_SUM;
      S_SUM:     state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tgt_q  <= sample_i.target;
      meas_q <= sample_i.measured;
    end
    unique case (state_q)
      S_ERR:     err_q <= {tgt_q, {FracBits{1'b0}}} - meas_q;
      S_MUL_I1:  p_q   <= mul_res;
      S_INT_ADD: i_q   <= acc_q + mul_res;
      S_D_ADD:   pd_q  <= p_q + mul_res;
      S_SUM:     sum_q <= in_window ? pd_q + i_q : pd_q;
      default: ;
    endcase
  end

  // Controller state: integrator and previous error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prev_q <= '0;
    end else if (in_accept && sample_i.clear_state) begin
      acc_q  <= '0;
      prev_q <= '0;
    end else if (state_q == S_SUM) begin
      acc_q  <= in_window ? i_q : '0;
      prev_q <= err_q;
    end
  end

  // Output register: load when free, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      drive_q <= clamped[FracBits +: DriveWidth];
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.drive = drive_q;

endmodule

`default_nettype wire
